### rtl/dictionary_spell_marker_defines.svh
// Assertion macros shared by the checker.
`ifndef DICTIONARY_SPELL_MARKER_DEFINES_SVH
`define DICTIONARY_SPELL_MARKER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define DSM_ASSERT(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition checked at each clock edge where the past value of reset is high.
`define DSM_ASSERT_RESET(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) $past(rst) |-> (cond)) else $error(msg);

`endif

### rtl/dsm_pkg.sv
`default_nettype none
package dsm_pkg;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_MARK  = 8'h5F;
   localparam logic [7:0] CASE_GAP = 8'd32;

   localparam logic OP_DICT = 1'b0;
   localparam logic OP_TEXT = 1'b1;

   typedef enum logic [2:0] {
      CLS_DICT,
      CLS_LETTER,
      CLS_PUNCT,
      CLS_END,
      CLS_DROP
   } class_type;

   typedef struct packed {
      class_type  cls;
      logic [7:0] ch;
   } item_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   // 9-bit sums so a high byte plus the gap never wraps
   function automatic logic same_byte(input logic [7:0] a, input logic [7:0] b);
      return (a == b) || (({1'b0, a} + {1'b0, CASE_GAP}) == {1'b0, b}) ||
             (({1'b0, b} + {1'b0, CASE_GAP}) == {1'b0, a});
   endfunction
endpackage
`default_nettype wire

### rtl/dsm_front.sv
`default_nettype none
// Classifies input bytes and queues them for the back end.
module dsm_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_operation,
   input  wire logic [7:0]         req_char_in,
   output logic                    q_valid,
   output dsm_pkg::item_type       q_item,
   input  wire logic               q_take
);
   import dsm_pkg::*;

   item_type   slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   item_type   new_item;
   logic       do_push, do_pop;

   always_comb begin
      new_item.ch = req_char_in;
      if (req_operation == OP_DICT) begin
         new_item.cls = CLS_DICT;
      end else if (is_letter(req_char_in)) begin
         new_item.cls = CLS_LETTER;
      end else if (req_char_in == CH_SPACE || req_char_in == CH_COMMA ||
                   req_char_in == CH_DOT || req_char_in == CH_BANG ||
                   req_char_in == CH_QUEST) begin
         new_item.cls = CLS_PUNCT;
      end else if (req_char_in == CH_NUL || req_char_in == CH_NL) begin
         new_item.cls = CLS_END;
      end else begin
         new_item.cls = CLS_DROP;
      end
   end

   assign req_full = (count_ff == 2'd2);
   assign do_push  = req_push && !req_full;
   assign q_valid  = (count_ff != 2'd0);
   assign do_pop   = q_take && q_valid;
   assign q_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end
endmodule
`default_nettype wire

### rtl/dsm_back.sv
`default_nettype none
// Carries out queued items: dictionary store, word buffer, lookup scan, output.
module dsm_back #(
   parameter int DICT_BYTES = 16384,
   parameter int WORD_MAX   = 20
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  dsm_pkg::item_type  q_item,
   output logic               q_take,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_last,
   output logic               rsp_text_end
);
   import dsm_pkg::*;

   localparam int AW = $clog2(DICT_BYTES);
   localparam int LW = $clog2(WORD_MAX + 1);
   localparam int WW = $clog2(WORD_MAX);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_REQ,
      ST_SCAN,
      ST_EMIT_OPEN,
      ST_EMIT_BUF,
      ST_EMIT_CLOSE,
      ST_EMIT_TAIL
   } state_type;

   logic [7:0]  dict_mem [DICT_BYTES];
   logic [7:0]  word_mem [WORD_MAX];
   logic [7:0]  dict_rd_ff;
   logic [7:0]  word_rd_ff;

   state_type   state_ff;
   logic [AW:0] dict_len_ff;
   logic [LW-1:0] word_len_ff;
   logic        long_ff;
   item_type    cur_ff;
   logic [AW:0] scan_addr_ff;
   logic [LW-1:0] scan_pos_ff;
   logic        entry_ok_ff;
   logic        found_ff;
   logic        long_emit_ff;
   logic [LW-1:0] emit_idx_ff;
   logic        rd_pending_ff;

   logic        out_valid_ff;
   logic [7:0]  out_char_ff;
   logic        out_last_ff, out_end_ff;

   logic        out_free;
   logic        out_load;
   logic        take;
   logic [AW-1:0] dict_rd_addr;
   logic [WW-1:0] word_rd_addr;

   assign out_free     = !out_valid_ff || rsp_pop;
   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_text_end = out_end_ff;
   assign take         = (state_ff == ST_IDLE) && q_valid;
   assign q_take       = take;

   // a new result enters the output register this cycle
   assign out_load = out_free && ((state_ff == ST_EMIT_OPEN && !found_ff) ||
                                  (state_ff == ST_EMIT_BUF && rd_pending_ff) ||
                                  state_ff == ST_EMIT_CLOSE || state_ff == ST_EMIT_TAIL);

   // next word buffer read follows the emit index
   always_comb begin
      dict_rd_addr = scan_addr_ff[AW-1:0];
      word_rd_addr = scan_pos_ff[WW-1:0];
      if (state_ff == ST_EMIT_OPEN || state_ff == ST_EMIT_BUF ||
          state_ff == ST_IDLE) begin
         word_rd_addr = emit_idx_ff[WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dict_rd_ff <= dict_mem[dict_rd_addr];
      word_rd_ff <= word_mem[word_rd_addr];
      if (take && q_item.cls == CLS_DICT && dict_len_ff < (AW+1)'(DICT_BYTES)) begin
         dict_mem[dict_len_ff[AW-1:0]] <= q_item.ch;
      end
      if (take && q_item.cls == CLS_LETTER && !long_ff &&
          word_len_ff < LW'(WORD_MAX)) begin
         word_mem[word_len_ff[WW-1:0]] <= q_item.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dict_len_ff   <= '0;
         word_len_ff   <= '0;
         long_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         rd_pending_ff <= 1'b0;
         emit_idx_ff   <= '0;
      end else begin
         if (rsp_pop && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               emit_idx_ff <= '0;
               if (take) begin
                  cur_ff <= q_item;
                  unique case (q_item.cls)
                     CLS_DICT: begin
                        if (dict_len_ff < (AW+1)'(DICT_BYTES)) begin
                           dict_len_ff <= dict_len_ff + 1'b1;
                        end
                     end
                     CLS_LETTER: begin
                        if (long_ff) begin
                           state_ff <= ST_EMIT_TAIL;
                        end else if (word_len_ff < LW'(WORD_MAX)) begin
                           word_len_ff <= word_len_ff + 1'b1;
                        end else begin
                           long_emit_ff <= 1'b1;
                           found_ff     <= 1'b0;
                           state_ff     <= ST_EMIT_OPEN;
                        end
                     end
                     CLS_PUNCT, CLS_END: begin
                        long_emit_ff <= 1'b0;
                        if (long_ff) begin
                           state_ff <= ST_EMIT_CLOSE;
                        end else if (word_len_ff != '0) begin
                           scan_addr_ff <= '0;
                           scan_pos_ff  <= '0;
                           entry_ok_ff  <= 1'b1;
                           found_ff     <= 1'b0;
                           state_ff     <= ST_SCAN_REQ;
                        end else if (q_item.cls == CLS_PUNCT) begin
                           state_ff <= ST_EMIT_TAIL;
                        end
                     end
                     CLS_DROP: begin
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN_REQ: begin
               // address presented; data next cycle
               if (scan_addr_ff >= dict_len_ff) begin
                  state_ff <= ST_EMIT_OPEN;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // compare one dictionary byte; the next one is requested from ST_SCAN_REQ
               if (dict_rd_ff == CH_NL) begin
                  if (entry_ok_ff && scan_pos_ff == word_len_ff) begin
                     found_ff <= 1'b1;
                     state_ff <= ST_EMIT_OPEN;
                  end else begin
                     state_ff <= ST_SCAN_REQ;
                  end
                  entry_ok_ff  <= 1'b1;
                  scan_pos_ff  <= '0;
                  scan_addr_ff <= scan_addr_ff + 1'b1;
               end else begin
                  if (scan_pos_ff >= word_len_ff || !same_byte(dict_rd_ff, word_rd_ff)) begin
                     entry_ok_ff <= 1'b0;
                  end
                  if (scan_pos_ff < word_len_ff) begin
                     scan_pos_ff <= scan_pos_ff + 1'b1;
                  end
                  scan_addr_ff <= scan_addr_ff + 1'b1;
                  if (scan_addr_ff + 1'b1 >= dict_len_ff) begin
                     // entry runs to the end of the store
                     if (entry_ok_ff && scan_pos_ff < word_len_ff &&
                         same_byte(dict_rd_ff, word_rd_ff) &&
                         scan_pos_ff + 1'b1 == word_len_ff) begin
                        found_ff <= 1'b1;
                     end
                     state_ff <= ST_EMIT_OPEN;
                  end else begin
                     state_ff <= ST_SCAN_REQ;
                  end
               end
            end
            ST_EMIT_OPEN: begin
               if (found_ff) begin
                  state_ff <= ST_EMIT_BUF;
               end else if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_char_ff  <= CH_MARK;
                  out_last_ff  <= 1'b0;
                  out_end_ff   <= (cur_ff.cls == CLS_END);
                  state_ff     <= ST_EMIT_BUF;
               end
               rd_pending_ff <= 1'b0;
            end
            ST_EMIT_BUF: begin
               if (!rd_pending_ff) begin
                  rd_pending_ff <= 1'b1;
               end else if (out_free) begin
                  out_valid_ff  <= 1'b1;
                  out_char_ff   <= word_rd_ff;
                  out_end_ff    <= (cur_ff.cls == CLS_END);
                  out_last_ff   <= (emit_idx_ff + 1'b1 == word_len_ff) && found_ff &&
                                   (cur_ff.cls == CLS_END);
                  emit_idx_ff   <= emit_idx_ff + 1'b1;
                  rd_pending_ff <= 1'b0;
                  if (emit_idx_ff + 1'b1 == word_len_ff) begin
                     word_len_ff <= '0;
                     if (long_emit_ff) begin
                        long_ff  <= 1'b1;
                        state_ff <= ST_EMIT_TAIL;
                     end else if (found_ff) begin
                        state_ff <= (cur_ff.cls == CLS_PUNCT) ? ST_EMIT_TAIL : ST_IDLE;
                     end else begin
                        state_ff <= ST_EMIT_CLOSE;
                     end
                  end
               end
            end
            ST_EMIT_CLOSE: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_char_ff  <= CH_MARK;
                  out_end_ff   <= (cur_ff.cls == CLS_END);
                  out_last_ff  <= (cur_ff.cls == CLS_END);
                  long_ff      <= 1'b0;
                  word_len_ff  <= '0;
                  state_ff     <= (cur_ff.cls == CLS_PUNCT) ? ST_EMIT_TAIL : ST_IDLE;
               end
            end
            ST_EMIT_TAIL: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_char_ff  <= cur_ff.ch;
                  out_end_ff   <= 1'b0;
                  out_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

### rtl/dictionary_spell_marker.sv
`default_nettype none
// Dictionary spell marker.
// Input queue: push/full with req_operation and req_char_in. Operation 0
// appends a byte to the dictionary store (newline separates words); operation
// 1 feeds a text character. A transfer happens when push is high and full low.
// Result queue: empty/pop with rsp_out_char, rsp_last, rsp_text_end; the oldest
// result shows while empty is low and is transferred when pop is high.
// Letters collect into a word; space , . ! ? end it and pass through; NUL or
// newline end it and close the text. A word not in the dictionary (case
// ignored) comes out wrapped in underscores. Other bytes are dropped.
// A dictionary byte is stored by the back end. A word end scans the dictionary
// store byte by byte (memory read then compare); the store's single read port
// paces the scan.
// A two-entry queue decouples classification from execution; a full result
// register stalls the back end, which stalls the queue and then req_full.
// Reset clears lengths, flags and queues; store contents stay undefined.
module dictionary_spell_marker #(
   parameter int DICT_BYTES = 16384,
   parameter int WORD_MAX   = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last,
   output logic            rsp_text_end
);
   import dsm_pkg::*;

   logic     q_valid, q_take;
   item_type q_item;

   dsm_front u_front (
      .clock, .reset, .req_push, .req_full, .req_operation, .req_char_in,
      .q_valid, .q_item, .q_take
   );

   dsm_back #(.DICT_BYTES(DICT_BYTES), .WORD_MAX(WORD_MAX)) u_back (
      .clock, .reset, .q_valid, .q_item, .q_take,
      .rsp_empty, .rsp_pop, .rsp_out_char, .rsp_last, .rsp_text_end
   );
endmodule
`default_nettype wire

### rtl/dsm_checker.sv
`default_nettype none
`include "dictionary_spell_marker_defines.svh"
module dsm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_last
);
   logic stalled;
   assign stalled = !rsp_empty && !rsp_pop;

   `DSM_ASSERT_RESET(a_empty_after_reset, clock, reset, rsp_empty, "result not empty after reset")
   `DSM_ASSERT_RESET(a_free_after_reset, clock, reset, !req_full, "full after reset")
   `DSM_ASSERT(a_hold_char, clock, reset, stalled |=> $stable(rsp_out_char), "char moved")
   `DSM_ASSERT(a_hold_last, clock, reset, stalled |=> $stable(rsp_last), "last moved")
   `DSM_ASSERT(a_keep_valid, clock, reset, stalled |=> !rsp_empty, "result dropped")
endmodule

bind dictionary_spell_marker dsm_checker u_chk (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_out_char, .rsp_last
);
`default_nettype wire

### tb/sv/dictionary_spell_marker_test.sv
`timescale 1ns / 100ps
`default_nettype none

module dictionary_spell_marker_test;
   import dsm_pkg::*;

   localparam int STORE_BYTES = 16384;
   localparam int LONGEST     = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_operation = OP_DICT;
   logic [7:0] req_char_in = CH_NUL;
   logic       rsp_pop = 1'b0;
   wire logic  req_full;
   wire logic  rsp_empty;
   wire logic [7:0] rsp_out_char;
   wire logic  rsp_last;
   wire logic  rsp_text_end;

   dictionary_spell_marker uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_operation(req_operation), .req_char_in(req_char_in),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_char(rsp_out_char), .rsp_last(rsp_last),
      .rsp_text_end(rsp_text_end)
   );

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       text_end;
   } echo_type;

   // shadow copy of the block's state
   logic [7:0] lexicon [STORE_BYTES];
   int         lexicon_len;
   logic [7:0] pending [LONGEST];
   int         pending_len;
   logic       overlong;

   echo_type   echo_queue [$];
   echo_type   batch [$];
   int         mismatches;
   int         echoes_seen;
   int         words_sent;
   int         chars_sent;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic letter_byte(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic bytes_match(input logic [7:0] a, input logic [7:0] b);
      return a == b || 9'(a) + 9'd32 == 9'(b) || 9'(b) + 9'd32 == 9'(a);
   endfunction

   // scan every newline-separated entry of the lexicon
   function automatic logic word_known();
      int  head;
      int  tail;
      logic hit;
      head = 0;
      while (head < lexicon_len) begin
         tail = head;
         while (tail < lexicon_len && lexicon[tail] != CH_NL) tail++;
         if (tail - head == pending_len && pending_len > 0) begin
            hit = 1'b1;
            for (int k = 0; k < pending_len; k++)
               if (!bytes_match(lexicon[head + k], pending[k])) hit = 1'b0;
            if (hit) return 1'b1;
         end
         head = tail + 1;
      end
      return 1'b0;
   endfunction

   function automatic void emit_byte(input logic [7:0] c);
      echo_type e;
      e.ch = c;
      e.last = 1'b0;
      e.text_end = 1'b0;
      batch.push_back(e);
   endfunction

   function automatic void close_word();
      logic known;
      if (overlong) begin
         emit_byte(CH_MARK);
         overlong = 1'b0;
      end else if (pending_len > 0) begin
         known = word_known();
         if (!known) emit_byte(CH_MARK);
         for (int k = 0; k < pending_len; k++) emit_byte(pending[k]);
         if (!known) emit_byte(CH_MARK);
      end
      pending_len = 0;
   endfunction

   // expected echo bytes for one accepted item
   function automatic void predict_echo(input logic op, input logic [7:0] c);
      logic closing;
      closing = 1'b0;
      batch.delete();
      if (op == OP_DICT) begin
         if (lexicon_len < STORE_BYTES) begin
            lexicon[lexicon_len] = c;
            lexicon_len++;
         end
         return;
      end
      if (letter_byte(c)) begin
         if (overlong) emit_byte(c);
         else if (pending_len < LONGEST) begin
            pending[pending_len] = c;
            pending_len++;
         end else begin
            emit_byte(CH_MARK);
            for (int k = 0; k < pending_len; k++) emit_byte(pending[k]);
            emit_byte(c);
            pending_len = 0;
            overlong = 1'b1;
         end
      end else if (c == CH_SPACE || c == CH_COMMA || c == CH_DOT ||
                   c == CH_BANG || c == CH_QUEST) begin
         close_word();
         emit_byte(c);
      end else if (c == CH_NUL || c == CH_NL) begin
         close_word();
         closing = 1'b1;
      end
      for (int k = 0; k < batch.size(); k++) begin
         batch[k].text_end = closing;
         batch[k].last = (k == batch.size() - 1);
         echo_queue.push_back(batch[k]);
      end
   endfunction

   // one transfer on the request side, after a random gap;
   // push stays high so a following item can go back to back
   task automatic send_byte(input logic op, input logic [7:0] c);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_operation <= op;
      req_char_in <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_echo(op, c);
      if (op == OP_TEXT) chars_sent++;
   endtask

   task automatic send_string(input logic op, input string s);
      for (int k = 0; k < s.len(); k++) send_byte(op, s[k]);
   endtask

   // wait until the block has drained every expected echo
   task automatic drain();
      req_push <= 1'b0;
      while (echo_queue.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result side: random stalls, compare each transfer
   initial begin
      int stall;
      echo_type want;
      mismatches = 0;
      echoes_seen = 0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 13);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         echoes_seen++;
         if (echo_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected echo: char %h last %b end %b",
                        rsp_out_char, rsp_last, rsp_text_end);
         end else begin
            want = echo_queue.pop_front();
            if (want.ch !== rsp_out_char || want.last !== rsp_last ||
                want.text_end !== rsp_text_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("echo mismatch: expected %h/%b/%b got %h/%b/%b",
                           want.ch, want.last, want.text_end,
                           rsp_out_char, rsp_last, rsp_text_end);
            end
         end
      end
   end

   // directed: dictionary, found and misspelled words, case, punctuation, dropped bytes
   task automatic test_basic_words();
      send_string(OP_DICT, "cat\ndog\n\nZ");
      send_string(OP_TEXT, "Cat dOg, cow!z?");
      send_byte(OP_TEXT, 8'hFF);      // dropped byte, no word pending
      send_byte(OP_TEXT, 8'h80);
      send_byte(OP_TEXT, CH_DOT);
      send_byte(OP_TEXT, CH_NL);      // nothing pending
      send_string(OP_TEXT, "ca");
      send_byte(OP_DICT, 8'h00);      // dictionary byte mid-word
      send_byte(OP_TEXT, CH_NUL);
      words_sent += 5;
      drain();
   endtask

   // directed: exactly max letters, then an overlong word streamed out
   task automatic test_long_words();
      for (int k = 0; k < LONGEST; k++) send_byte(OP_TEXT, "a");
      send_byte(OP_TEXT, CH_SPACE);
      for (int k = 0; k < LONGEST + 3; k++) send_byte(OP_TEXT, "B");
      send_byte(OP_TEXT, CH_NL);
      words_sent += 2;
      drain();
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] c;
      c = 8'h41 + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1)) c = c + CASE_GAP;
      return c;
   endfunction

   // random: small lexicon of short words, text mostly from those words
   task automatic test_random_text();
      string vocab [6];
      logic [7:0] seps [6];
      int pick;
      int len;
      seps = '{CH_SPACE, CH_COMMA, CH_DOT, CH_BANG, CH_QUEST, CH_NL};
      for (int w = 0; w < 6; w++) begin
         len = $urandom_range(1, 4);
         vocab[w] = "";
         for (int k = 0; k < len; k++) vocab[w] = {vocab[w], string'(random_letter())};
         send_string(OP_DICT, vocab[w]);
         send_byte(OP_DICT, CH_NL);
      end
      while (chars_sent < 110) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            for (int k = 0; k < vocab[pick].len(); k++) begin
               logic [7:0] c;
               c = vocab[pick][k];
               if ($urandom_range(0, 1)) c = c ^ CASE_GAP;
               send_byte(OP_TEXT, c);
            end
         end else if (pick < 9) begin
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++) send_byte(OP_TEXT, random_letter());
         end else begin
            send_byte($urandom_range(0, 3) == 0 ? OP_DICT : OP_TEXT,
                      8'($urandom_range(0, 255)));
         end
         words_sent++;
         send_byte(OP_TEXT, seps[$urandom_range(0, 5)]);
         if (words_sent == 15) drain();     // sender holds off once
      end
      send_byte(OP_TEXT, CH_NUL);
      drain();
   endtask

   initial begin
      lexicon_len = 0;
      pending_len = 0;
      overlong = 1'b0;
      words_sent = 0;
      chars_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_words();
      test_long_words();
      test_random_text();
      $display("covered %0d words in %0d text bytes, %0d echo bytes checked",
               words_sent, chars_sent, echoes_seen);
      if (mismatches == 0 && echo_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule

`default_nettype wire
